// ===== src/cgs_pkg.sv =====
// Package for the coarse-to-fine grid stigmator search.
// Holds the stage geometry, the status and operation codes and the coordinate saturation.
// No dependencies.
package cgs_pkg;

  localparam int CGS_COORD_BITS_DEF = 12;
  localparam int CGS_SHARP_BITS_DEF = 32;
  localparam int CGS_GRID_POINTS    = 16;
  localparam int CGS_WIDE_BITS      = 19;
  localparam int CGS_COARSE_ORIGIN  = -1536;

  localparam logic [1:0] CGS_LAST_STAGE = 2'd3;

  localparam int CGS_STEP_LOG2    [4] = '{10, 8, 6, 3};
  localparam int CGS_STAGE_OFFSET [4] = '{0, -385, -97, -16};

  localparam logic OP_START   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_DONE     = 2'd1,
    ST_IDLE     = 2'd2
  } status_t;

  typedef logic signed [CGS_WIDE_BITS-1:0] wide_t;

  function automatic wide_t cgs_sat(input wide_t v, input int cb);
    wide_t hi;
    wide_t lo;
    hi = CGS_WIDE_BITS'((1 << (cb - 1)) - 1);
    lo = ~hi;
    if (v > hi) begin
      cgs_sat = hi;
    end else if (v < lo) begin
      cgs_sat = lo;
    end else begin
      cgs_sat = v;
    end
  endfunction

endpackage

// ===== src/cgs_if.sv =====
// Valid/ready channel interfaces for the grid stigmator search.
// Depends on cgs_pkg for default widths and the status type.
interface cgs_in_if #(
  parameter int SHARP_BITS = cgs_pkg::CGS_SHARP_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [SHARP_BITS-1:0] sharpness;

  modport source (output valid, output op, output sharpness, input ready);
  modport sink   (input valid, input op, input sharpness, output ready);
endinterface

interface cgs_out_if #(
  parameter int COORD_BITS = cgs_pkg::CGS_COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] stig_x;
  logic signed [COORD_BITS-1:0] stig_y;
  cgs_pkg::status_t             status;

  modport source (output valid, output stig_x, output stig_y, output status, input ready);
  modport sink   (input valid, input stig_x, input stig_y, input status, output ready);
endinterface

// ===== src/cgs_point_gen.sv =====
// Grid point generator: serpentine position of one point from origin, stage and index.
// Depends on cgs_pkg.
module cgs_point_gen #(
  parameter int COORD_BITS = cgs_pkg::CGS_COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] org_x,
  input  logic signed [COORD_BITS-1:0] org_y,
  input  logic [1:0]                   stage,
  input  logic [3:0]                   idx,
  output logic signed [COORD_BITS-1:0] pt_x,
  output logic signed [COORD_BITS-1:0] pt_y
);
  import cgs_pkg::*;

  logic [1:0] col;
  logic [1:0] row;
  logic [3:0] shamt;
  wide_t      dx;
  wide_t      dy;
  wide_t      sum_x;
  wide_t      sum_y;
  wide_t      sat_x;
  wide_t      sat_y;

  always_comb begin
    row   = idx[3:2];
    col   = row[0] ? ~idx[1:0] : idx[1:0];
    shamt = 4'(CGS_STEP_LOG2[stage]);
    dx    = $signed(CGS_WIDE_BITS'(col) << shamt);
    dy    = $signed(CGS_WIDE_BITS'(row) << shamt);
    sum_x = CGS_WIDE_BITS'(org_x) + dx;
    sum_y = CGS_WIDE_BITS'(org_y) + dy;
    sat_x = cgs_sat(sum_x, COORD_BITS);
    sat_y = cgs_sat(sum_y, COORD_BITS);
  end

  assign pt_x = sat_x[COORD_BITS-1:0];
  assign pt_y = sat_y[COORD_BITS-1:0];

endmodule

// ===== src/cgs_engine.sv =====
// Search engine: stage, point index, grid origin and running best, plus next-point logic.
// Depends on cgs_pkg and cgs_point_gen.
module cgs_engine #(
  parameter int COORD_BITS = cgs_pkg::CGS_COORD_BITS_DEF,
  parameter int SHARP_BITS = cgs_pkg::CGS_SHARP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic                         op,
  input  logic [SHARP_BITS-1:0]        sharp,
  output logic signed [COORD_BITS-1:0] res_x,
  output logic signed [COORD_BITS-1:0] res_y,
  output cgs_pkg::status_t             res_status
);
  import cgs_pkg::*;

  localparam logic signed [COORD_BITS-1:0] START_ORG = COORD_BITS'(CGS_COARSE_ORIGIN);
  localparam logic [3:0] LAST_POINT = 4'(CGS_GRID_POINTS - 1);

  logic                         running_r, running_nxt;
  logic [1:0]                   stage_r, stage_nxt;
  logic [3:0]                   idx_r, idx_nxt;
  logic signed [COORD_BITS-1:0] org_x_r, org_x_nxt;
  logic signed [COORD_BITS-1:0] org_y_r, org_y_nxt;
  logic [SHARP_BITS-1:0]        best_r, best_nxt;
  logic signed [COORD_BITS-1:0] held_x_r, held_x_nxt;
  logic signed [COORD_BITS-1:0] held_y_r, held_y_nxt;

  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic signed [COORD_BITS-1:0] nxt_x, nxt_y;
  logic signed [COORD_BITS-1:0] hn_x, hn_y;
  logic [1:0]                   stage_inc;
  logic                         take;
  wide_t                        org_wx, org_wy;

  cgs_point_gen #(.COORD_BITS(COORD_BITS)) u_cur (
    .org_x(org_x_r), .org_y(org_y_r), .stage(stage_r), .idx(idx_r),
    .pt_x(cur_x), .pt_y(cur_y)
  );

  cgs_point_gen #(.COORD_BITS(COORD_BITS)) u_nxt (
    .org_x(org_x_r), .org_y(org_y_r), .stage(stage_r), .idx(idx_r + 4'd1),
    .pt_x(nxt_x), .pt_y(nxt_y)
  );

  always_comb begin
    take      = (idx_r == '0) || (sharp > best_r);
    hn_x      = take ? cur_x : held_x_r;
    hn_y      = take ? cur_y : held_y_r;
    stage_inc = stage_r + 2'd1;
    org_wx    = cgs_sat(CGS_WIDE_BITS'(hn_x) + CGS_WIDE_BITS'(CGS_STAGE_OFFSET[stage_inc]),
                        COORD_BITS);
    org_wy    = cgs_sat(CGS_WIDE_BITS'(hn_y) + CGS_WIDE_BITS'(CGS_STAGE_OFFSET[stage_inc]),
                        COORD_BITS);
  end

  always_comb begin
    running_nxt = running_r;
    stage_nxt   = stage_r;
    idx_nxt     = idx_r;
    org_x_nxt   = org_x_r;
    org_y_nxt   = org_y_r;
    best_nxt    = best_r;
    held_x_nxt  = held_x_r;
    held_y_nxt  = held_y_r;
    res_x       = '0;
    res_y       = '0;
    res_status  = ST_IDLE;
    priority if (op == OP_START) begin
      running_nxt = 1'b1;
      stage_nxt   = '0;
      idx_nxt     = '0;
      org_x_nxt   = START_ORG;
      org_y_nxt   = START_ORG;
      best_nxt    = '0;
      held_x_nxt  = '0;
      held_y_nxt  = '0;
      res_x       = START_ORG;
      res_y       = START_ORG;
      res_status  = ST_CONTINUE;
    end else if (!running_r) begin
      res_status = ST_IDLE;
    end else begin
      best_nxt   = take ? sharp : best_r;
      held_x_nxt = hn_x;
      held_y_nxt = hn_y;
      priority if (idx_r != LAST_POINT) begin
        idx_nxt    = idx_r + 4'd1;
        res_x      = nxt_x;
        res_y      = nxt_y;
        res_status = ST_CONTINUE;
      end else if (stage_r == CGS_LAST_STAGE) begin
        running_nxt = 1'b0;
        res_x       = hn_x;
        res_y       = hn_y;
        res_status  = ST_DONE;
      end else begin
        stage_nxt  = stage_inc;
        idx_nxt    = '0;
        best_nxt   = '0;
        org_x_nxt  = org_wx[COORD_BITS-1:0];
        org_y_nxt  = org_wy[COORD_BITS-1:0];
        res_x      = org_wx[COORD_BITS-1:0];
        res_y      = org_wy[COORD_BITS-1:0];
        res_status = ST_CONTINUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      stage_r   <= '0;
      idx_r     <= '0;
      org_x_r   <= START_ORG;
      org_y_r   <= START_ORG;
      best_r    <= '0;
      held_x_r  <= '0;
      held_y_r  <= '0;
    end else if (advance) begin
      running_r <= running_nxt;
      stage_r   <= stage_nxt;
      idx_r     <= idx_nxt;
      org_x_r   <= org_x_nxt;
      org_y_r   <= org_y_nxt;
      best_r    <= best_nxt;
      held_x_r  <= held_x_nxt;
      held_y_r  <= held_y_nxt;
    end
  end

  a_start_resets: assert property (@(posedge clk) disable iff (!rst_n)
    advance && op == OP_START |=> running_r && idx_r == '0 && stage_r == '0)
    else $error("start item did not restart the coarse stage");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    advance && op == OP_MEASURE && !running_r |=> $stable(idx_r) && $stable(stage_r)
      && !running_r)
    else $error("idle measure item changed the search state");

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_status == ST_DONE |=> !running_r)
    else $error("search still running after completion");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_status == ST_IDLE |-> res_x == '0 && res_y == '0 && !running_r)
    else $error("idle result carries a point");

endmodule

// ===== src/coarse_to_fine_grid_stigmator_search_core.sv =====
// Top level of the coarse-to-fine grid stigmator search: input register, engine, result register.
// Depends on cgs_pkg, cgs_if and cgs_engine.
//
// Usage: in_ch carries items with op (start or measure) and sharpness. A start item
// begins a new search and answers with the first coarse grid point. Each measure item
// gives the sharpness at the point last handed out and answers with the next point to
// apply; after sixteen points of the last stage the answer is the best point with
// status completed. A measure item while no search runs answers with status idle.
// Every item gives exactly one result item on out_ch.
// An accepted item waits in the input register until the result register is free or
// being read, then moves into it. Throughput: one item per cycle while out_ch does not
// stall; the input register and the result register form two stages, and the engine
// updates its state in the cycle an item moves between them. When out_ch stalls, one
// more item can wait in the input register before in_ch.ready drops. Reset clears the
// valid flags of both registers, empties the channel and leaves the search idle.
module coarse_to_fine_grid_stigmator_search_core #(
  parameter int COORD_BITS = cgs_pkg::CGS_COORD_BITS_DEF,
  parameter int SHARP_BITS = cgs_pkg::CGS_SHARP_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cgs_in_if.sink     in_ch,
  cgs_out_if.source  out_ch
);
  import cgs_pkg::*;

  logic                         in_valid_r;
  logic                         in_op_r;
  logic [SHARP_BITS-1:0]        in_sharp_r;
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r;
  logic signed [COORD_BITS-1:0] out_y_r;
  status_t                      out_status_r;

  logic                         advance;
  logic                         in_accept;
  logic signed [COORD_BITS-1:0] res_x;
  logic signed [COORD_BITS-1:0] res_y;
  status_t                      res_status;

  assign advance   = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_accept = in_ch.valid && in_ch.ready;

  assign in_ch.ready   = !in_valid_r || advance;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.stig_x = out_x_r;
  assign out_ch.stig_y = out_y_r;
  assign out_ch.status = out_status_r;

  cgs_engine #(.COORD_BITS(COORD_BITS), .SHARP_BITS(SHARP_BITS)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .op         (in_op_r),
    .sharp      (in_sharp_r),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_status (res_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_op_r    <= in_ch.op;
      in_sharp_r <= SHARP_BITS'(in_ch.sharpness);
    end
    if (advance) begin
      out_x_r      <= res_x;
      out_y_r      <= res_y;
      out_status_r <= res_status;
    end
  end

endmodule

// ===== tb/sv/tb_coarse_to_fine_grid_stigmator_search_core.sv =====
// Self-checking testbench for the coarse-to-fine grid stigmator search core.
// It predicts every result item from its own model of the serpentine grid search and
// compares each one; depends on cgs_pkg, the cgs_if interfaces and the core itself.
module tb_coarse_to_fine_grid_stigmator_search_core;
  import cgs_pkg::*;

  localparam int COORD_BITS  = CGS_COORD_BITS_DEF;
  localparam int SHARP_BITS  = CGS_SHARP_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int STEP_SIZE [4] = '{1024, 256, 64, 8};

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    status_t                      status;
  } stig_setting_t;

  logic clk;
  logic rst_n;

  cgs_in_if  #(.SHARP_BITS(SHARP_BITS)) in_ch ();
  cgs_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

  coarse_to_fine_grid_stigmator_search_core #(
    .COORD_BITS(COORD_BITS),
    .SHARP_BITS(SHARP_BITS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stig_setting_t awaited_settings [$];
  stig_setting_t arrived;

  bit              srch_running;
  logic [1:0]      srch_stage;
  logic [3:0]      srch_idx;
  int              org_x;
  int              org_y;
  logic [SHARP_BITS-1:0] best_sharp;
  int              held_x;
  int              held_y;
  int              probe_x;
  int              probe_y;

  bit          gaps_on;
  int unsigned rx_hold;
  int unsigned rx_gap;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned searches_done;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic int clamp_coord(input int v);
    int hi;
    int lo;
    hi = (1 << (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void grid_point(input logic [3:0] idx, output int x, output int y);
    int row;
    int col;
    row = int'(idx[3:2]);
    col = int'(idx[1:0]);
    if (row % 2 == 1) col = 3 - col;
    x = clamp_coord(org_x + STEP_SIZE[srch_stage] * col);
    y = clamp_coord(org_y + STEP_SIZE[srch_stage] * row);
  endfunction

  function automatic void predict_search(input logic op, input logic [SHARP_BITS-1:0] sharp);
    stig_setting_t r;
    int px;
    int py;
    int step;
    int ofs;
    r.status = ST_CONTINUE;
    if (op == OP_START) begin
      srch_running = 1'b1;
      srch_stage = 2'd0;
      srch_idx = 4'd0;
      org_x = CGS_COARSE_ORIGIN;
      org_y = CGS_COARSE_ORIGIN;
      best_sharp = '0;
      held_x = 0;
      held_y = 0;
      grid_point(4'd0, px, py);
    end else if (!srch_running) begin
      px = 0;
      py = 0;
      r.status = ST_IDLE;
    end else begin
      if (srch_idx == 4'd0 || sharp > best_sharp) begin
        best_sharp = sharp;
        grid_point(srch_idx, held_x, held_y);
      end
      if (srch_idx != 4'(CGS_GRID_POINTS - 1)) begin
        srch_idx = srch_idx + 4'd1;
        grid_point(srch_idx, px, py);
      end else if (srch_stage == CGS_LAST_STAGE) begin
        srch_running = 1'b0;
        px = held_x;
        py = held_y;
        r.status = ST_DONE;
        searches_done++;
      end else begin
        srch_stage = srch_stage + 2'd1;
        step = STEP_SIZE[srch_stage];
        ofs = (srch_stage == CGS_LAST_STAGE) ? -2 * step : step / 2 - 1 - 2 * step;
        org_x = clamp_coord(held_x + ofs);
        org_y = clamp_coord(held_y + ofs);
        srch_idx = 4'd0;
        best_sharp = '0;
        grid_point(4'd0, px, py);
      end
    end
    r.x = COORD_BITS'(px);
    r.y = COORD_BITS'(py);
    if (r.status == ST_CONTINUE) begin
      probe_x = px;
      probe_y = py;
    end
    awaited_settings.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_item(input logic op, input logic [SHARP_BITS-1:0] sharp);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.sharpness <= sharp;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
    predict_search(op, sharp);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (awaited_settings.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SHARP_BITS-1:0] next_sharpness(input int mode, input int tx,
                                                           input int ty);
    int dx;
    int dy;
    case (mode)
      0: return SHARP_BITS'($urandom);
      1: return SHARP_BITS'($urandom_range(3));
      2: begin
        dx = (probe_x > tx) ? probe_x - tx : tx - probe_x;
        dy = (probe_y > ty) ? probe_y - ty : ty - probe_y;
        return {SHARP_BITS{1'b1}} - SHARP_BITS'(1000 * (dx + dy));
      end
      default: begin
        case ($urandom_range(2))
          0: return '0;
          1: return '1;
          default: return SHARP_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      rx_gap = gaps_on ? pick_gap() : 0;
      if (rx_gap == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        rx_hold <= rx_gap - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (awaited_settings.size() == 0) begin
        report_mismatch("unexpected result item, stig_x", int'(out_ch.stig_x), 0);
      end else begin
        arrived = awaited_settings.pop_front();
        if (out_ch.stig_x !== arrived.x) begin
          report_mismatch("stig_x", int'(out_ch.stig_x), int'(arrived.x));
        end
        if (out_ch.stig_y !== arrived.y) begin
          report_mismatch("stig_y", int'(out_ch.stig_y), int'(arrived.y));
        end
        if (out_ch.status !== arrived.status) begin
          report_mismatch("status", int'(out_ch.status), int'(arrived.status));
        end
      end
    end
  end

  task automatic test_idle_measure();
    send_item(OP_MEASURE, '0);
    send_item(OP_MEASURE, '1);
  endtask

  task automatic test_flat_stage();
    send_item(OP_START, '1);
    repeat (CGS_GRID_POINTS) send_item(OP_MEASURE, '0);
    send_item(OP_MEASURE, '1);
    send_item(OP_MEASURE, '0);
  endtask

  task automatic test_restart_while_running();
    send_item(OP_START, '0);
    send_item(OP_MEASURE, SHARP_BITS'(32'h0001_0000));
    send_item(OP_START, '1);
    wait_for_results();
  endtask

  task automatic test_random_searches();
    int mode;
    int tx;
    int ty;
    int n_measure;
    int search_no;
    search_no = 0;
    while (items_sent < 1025) begin
      mode = $urandom_range(3);
      tx = $urandom_range(4095) - 2048;
      ty = $urandom_range(4095) - 2048;
      gaps_on = ($urandom_range(3) != 0);
      n_measure = 4 * CGS_GRID_POINTS;
      if ($urandom_range(99) < 15) n_measure = $urandom_range(4 * CGS_GRID_POINTS - 1, 1);
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(4, 1)) send_item(logic'($urandom_range(1)), SHARP_BITS'($urandom));
      end
      send_item(OP_START, SHARP_BITS'($urandom));
      repeat (n_measure) send_item(OP_MEASURE, next_sharpness(mode, tx, ty));
      if (n_measure == 4 * CGS_GRID_POINTS && $urandom_range(99) < 30) begin
        repeat ($urandom_range(3, 1)) send_item(OP_MEASURE, SHARP_BITS'($urandom));
      end
      search_no++;
      if (search_no % 4 == 0) wait_for_results();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_wind_down();
    gaps_on = 1'b0;
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d items and checked %0d results, %0d searches ran to completion.",
             items_sent, results_checked, searches_done);
    $display("Covered idle measures, flat and tied stages, restarts and random sharpness maps.");
    if (error_count == 0 && awaited_settings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_MEASURE;
    in_ch.sharpness <= '0;
    gaps_on         = 1'b1;
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    searches_done   = 0;
    srch_running    = 1'b0;
    srch_stage      = 2'd0;
    srch_idx        = 4'd0;
    org_x           = CGS_COARSE_ORIGIN;
    org_y           = CGS_COARSE_ORIGIN;
    best_sharp      = '0;
    held_x          = 0;
    held_y          = 0;
    probe_x         = 0;
    probe_y         = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_measure();
    test_flat_stage();
    test_restart_while_running();
    test_random_searches();
    test_wind_down();
  end

endmodule
